// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the top-k selector checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TKS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: %m");

// Next-cycle implication, disabled while reset is asserted.
`define TKS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: %m");

`endif

// ===== src/tks_pkg.sv =====
// ---------------------------------------------------------------------------
// tks_pkg
// Types and fixed constants shared by the top-k score selector.
// ---------------------------------------------------------------------------
package tks_pkg;

	// configuration port
	localparam int CFG_INDEX_WIDTH = 1;
	localparam int CFG_DATA_WIDTH  = 5;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HIGHER_IS_BETTER = 1'b0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TOP_K            = 1'b1;

	localparam logic       HIB_RESET   = 1'b1;
	localparam logic [4:0] TOP_K_RESET = 5'd16;

	// item operations
	localparam logic OP_OFFER  = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// result rank field, and width used to clamp top_k (MAX_KEEP <= 256)
	localparam int RANK_W    = 4;
	localparam int K_CALC_W  = 9;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     higher_is_better;
	} cell_ctrl_t;

	typedef enum logic {
		ST_ACCEPT,
		ST_DRAIN
	} tks_state_t;

endpackage

// ===== src/tks_ifs.sv =====
// ---------------------------------------------------------------------------
// tks_ifs
// Valid/ready channel interfaces: item input, result output, config write.
// ---------------------------------------------------------------------------
interface tks_item_if #(parameter int SCORE_WIDTH = 32);
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic signed [SCORE_WIDTH-1:0] score;

	modport source (output valid, output operation, output score, input ready);
	modport sink   (input valid, input operation, input score, output ready);
endinterface

interface tks_result_if #(parameter int SCORE_WIDTH = 32, parameter int INDEX_WIDTH = 20);
	logic                          valid;
	logic                          ready;
	logic signed [SCORE_WIDTH-1:0] rank_score;
	logic [INDEX_WIDTH-1:0]        entry_index;
	logic [tks_pkg::RANK_W-1:0]    rank;
	logic                          empty_res;
	logic                          overflow;
	logic                          last;

	modport source (output valid, output rank_score, output entry_index, output rank,
		output empty_res, output overflow, output last, input ready);
	modport sink   (input valid, input rank_score, input entry_index, input rank,
		input empty_res, input overflow, input last, output ready);
endinterface

interface tks_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [tks_pkg::CFG_INDEX_WIDTH-1:0]  index;
	logic [tks_pkg::CFG_DATA_WIDTH-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/tks_cell.sv =====
// ---------------------------------------------------------------------------
// tks_cell
// One slot of the sorted insertion row: holds a score and its entry index.
// ---------------------------------------------------------------------------
module tks_cell #(
	parameter int SCORE_WIDTH = 32,
	parameter int INDEX_WIDTH = 20
) (
	input  logic                          clk,
	input  tks_pkg::cell_ctrl_t           ctrl,
	input  logic                          valid,
	input  logic signed [SCORE_WIDTH-1:0] new_score,
	input  logic [INDEX_WIDTH-1:0]        new_index,
	input  logic                          left_keep,
	input  logic signed [SCORE_WIDTH-1:0] left_score,
	input  logic [INDEX_WIDTH-1:0]        left_index,
	input  logic signed [SCORE_WIDTH-1:0] right_score,
	input  logic [INDEX_WIDTH-1:0]        right_index,
	output logic signed [SCORE_WIDTH-1:0] score,
	output logic [INDEX_WIDTH-1:0]        index,
	output logic                          keep
);

	logic signed [SCORE_WIDTH-1:0] score_q;
	logic [INDEX_WIDTH-1:0]        index_q;

	// ties keep the stored entry (it arrived first)
	always_comb begin
		if (ctrl.higher_is_better) begin
			keep = valid && (score_q >= new_score);
		end else begin
			keep = valid && (score_q <= new_score);
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			tks_pkg::CELL_INSERT: begin
				if (!keep) begin
					if (left_keep) begin
						score_q <= new_score;
						index_q <= new_index;
					end else begin
						score_q <= left_score;
						index_q <= left_index;
					end
				end
			end
			tks_pkg::CELL_SHIFT: begin
				score_q <= right_score;
				index_q <= right_index;
			end
			default: begin
			end
		endcase
	end

	assign score = score_q;
	assign index = index_q;

endmodule

// ===== src/top_k_score_select.sv =====
// ---------------------------------------------------------------------------
// top_k_score_select
// Streaming top-k selector over a row of sorted insertion cells.
// ---------------------------------------------------------------------------
// Each offer transaction numbers one entry and is folded into a row of
// MAX_KEEP cells kept sorted best first; offers are taken one per clock with
// no gaps. A finish transaction closes the query: input ready then drops and
// the row shifts out toward the result register, one ranked result per
// cycle while the result side is ready; an empty query yields one empty
// result. Input ready returns once the last result is loaded. Ties go to the
// lower entry index. After 2^INDEX_WIDTH offers further offers are dropped
// and flagged in every result of the next finish. No clearing pass runs
// after reset; the block takes transactions as soon as reset is released.
// ---------------------------------------------------------------------------
module top_k_score_select #(
	parameter int MAX_KEEP    = 16,
	parameter int INDEX_WIDTH = 20,
	parameter int SCORE_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	tks_cfg_if.sink      cfg,
	tks_item_if.sink     item,
	tks_result_if.source result
);

	localparam int KW = $clog2(MAX_KEEP + 1);
	localparam int CW = INDEX_WIDTH + 1;
	localparam int RW = tks_pkg::RANK_W;
	localparam int XW = tks_pkg::K_CALC_W;

	// config registers
	logic       hib_q;
	logic [4:0] top_k_q;

	// query state
	logic [KW-1:0] kept_count_q;
	logic [CW-1:0] entries_seen_q;
	logic          overflow_seen_q;

	// drain state
	tks_pkg::tks_state_t state_q, state_d;
	logic [KW-1:0] drain_n_q;
	logic [KW-1:0] rank_q;
	logic          drain_ovf_q;

	// result register
	logic                          res_valid_q;
	logic signed [SCORE_WIDTH-1:0] res_score_q;
	logic [INDEX_WIDTH-1:0]        res_index_q;
	logic [RW-1:0]                 res_rank_q;
	logic                          res_empty_q;
	logic                          res_ovf_q;
	logic                          res_last_q;

	logic [XW-1:0] k_wide;
	logic [KW-1:0] eff_k;
	logic [KW-1:0] n_cur;
	logic [KW-1:0] n_next;

	logic signed [SCORE_WIDTH-1:0] cell_score [MAX_KEEP];
	logic [INDEX_WIDTH-1:0]        cell_index [MAX_KEEP];
	logic [MAX_KEEP-1:0]           cell_keep;
	logic [MAX_KEEP-1:0]           cell_valid;
	logic [MAX_KEEP-1:0]           at_k_end;

	logic                 item_ready;
	logic                 item_acc;
	logic                 offer_go;
	logic                 finish_go;
	logic                 index_full;
	logic                 insert_ok;
	logic                 out_free;
	logic                 drain_load;
	logic                 drain_empty;
	logic                 drain_last;
	logic [INDEX_WIDTH-1:0] new_index;
	tks_pkg::cell_ctrl_t  cell_ctrl;

	// ---------------------------------------------------------------------
	// Configuration writes, always accepted
	// ---------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hib_q   <= tks_pkg::HIB_RESET;
			top_k_q <= tks_pkg::TOP_K_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tks_pkg::CFG_HIGHER_IS_BETTER: hib_q   <= cfg.data[0];
				tks_pkg::CFG_TOP_K:            top_k_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// effective k: zero acts as one, clamp to the row length
	always_comb begin
		k_wide = XW'(top_k_q);
		if (k_wide == '0) begin
			k_wide = XW'(1);
		end else if (k_wide > XW'(MAX_KEEP)) begin
			k_wide = XW'(MAX_KEEP);
		end
		eff_k = KW'(k_wide);
	end

	// live length; a shrunk k cuts the list here
	assign n_cur = (kept_count_q < eff_k) ? kept_count_q : eff_k;

	// ---------------------------------------------------------------------
	// Input side
	// ---------------------------------------------------------------------
	assign item.ready = item_ready;
	assign item_acc   = item.valid && item_ready;
	assign index_full = entries_seen_q[INDEX_WIDTH];
	assign offer_go   = item_acc && (item.operation == tks_pkg::OP_OFFER) && !index_full;
	assign finish_go  = item_acc && (item.operation == tks_pkg::OP_FINISH);
	assign new_index  = entries_seen_q[INDEX_WIDTH-1:0];

	// the new score is dropped only if all k live slots keep their entry
	assign insert_ok = !(|(cell_keep & at_k_end));
	assign n_next    = insert_ok ? ((n_cur < eff_k) ? n_cur + 1'b1 : eff_k) : n_cur;

	// ---------------------------------------------------------------------
	// Insertion row
	// ---------------------------------------------------------------------
	always_comb begin
		cell_ctrl.higher_is_better = hib_q;
		if (offer_go) begin
			cell_ctrl.op = tks_pkg::CELL_INSERT;
		end else if (drain_load && !drain_empty) begin
			cell_ctrl.op = tks_pkg::CELL_SHIFT;
		end else begin
			cell_ctrl.op = tks_pkg::CELL_HOLD;
		end
	end

	for (genvar j = 0; j < MAX_KEEP; j++) begin : g_cell
		logic                          lk;
		logic signed [SCORE_WIDTH-1:0] ls;
		logic [INDEX_WIDTH-1:0]        li;
		logic signed [SCORE_WIDTH-1:0] rs;
		logic [INDEX_WIDTH-1:0]        ri;

		// head cell sees an always-kept left neighbor, so it takes the new entry
		if (j == 0) begin : g_head
			assign lk = 1'b1;
			assign ls = item.score;
			assign li = new_index;
		end else begin : g_body
			assign lk = cell_keep[j-1];
			assign ls = cell_score[j-1];
			assign li = cell_index[j-1];
		end

		if (j == MAX_KEEP - 1) begin : g_tail
			assign rs = cell_score[j];
			assign ri = cell_index[j];
		end else begin : g_mid
			assign rs = cell_score[j+1];
			assign ri = cell_index[j+1];
		end

		assign cell_valid[j] = KW'(j) < n_cur;
		assign at_k_end[j]   = KW'(j) == (eff_k - 1'b1);

		tks_cell #(
			.SCORE_WIDTH(SCORE_WIDTH),
			.INDEX_WIDTH(INDEX_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.valid      (cell_valid[j]),
			.new_score  (item.score),
			.new_index  (new_index),
			.left_keep  (lk),
			.left_score (ls),
			.left_index (li),
			.right_score(rs),
			.right_index(ri),
			.score      (cell_score[j]),
			.index      (cell_index[j]),
			.keep       (cell_keep[j])
		);
	end

	// ---------------------------------------------------------------------
	// Query counters
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_count_q    <= '0;
			entries_seen_q  <= '0;
			overflow_seen_q <= 1'b0;
			drain_n_q       <= '0;
			drain_ovf_q     <= 1'b0;
			rank_q          <= '0;
		end else begin
			if (finish_go) begin
				kept_count_q    <= '0;
				entries_seen_q  <= '0;
				overflow_seen_q <= 1'b0;
				drain_n_q       <= n_cur;
				drain_ovf_q     <= overflow_seen_q;
				rank_q          <= '0;
			end else if (item_acc) begin
				if (index_full) begin
					overflow_seen_q <= 1'b1;
				end else begin
					entries_seen_q <= entries_seen_q + 1'b1;
					kept_count_q   <= n_next;
				end
			end
			if (drain_load && !drain_empty) begin
				rank_q <= rank_q + 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Drain sequencer
	// ---------------------------------------------------------------------
	assign out_free    = !res_valid_q || result.ready;
	assign drain_empty = (drain_n_q == '0);
	assign drain_last  = drain_empty || (rank_q == drain_n_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tks_pkg::ST_ACCEPT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		drain_load = 1'b0;
		unique case (state_q)
			tks_pkg::ST_ACCEPT: begin
				item_ready = 1'b1;
				if (finish_go) begin
					state_d = tks_pkg::ST_DRAIN;
				end
			end
			tks_pkg::ST_DRAIN: begin
				if (out_free) begin
					drain_load = 1'b1;
					if (drain_last) begin
						state_d = tks_pkg::ST_ACCEPT;
					end
				end
			end
			default: begin
				state_d = tks_pkg::ST_ACCEPT;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// Result register; the head cell is always the next rank
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (drain_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_load) begin
			res_score_q <= drain_empty ? '0 : cell_score[0];
			res_index_q <= drain_empty ? '0 : cell_index[0];
			res_rank_q  <= drain_empty ? '0 : RW'(rank_q);
			res_empty_q <= drain_empty;
			res_ovf_q   <= drain_ovf_q;
			res_last_q  <= drain_last;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.rank_score  = res_score_q;
	assign result.entry_index = res_index_q;
	assign result.rank        = res_rank_q;
	assign result.empty_res   = res_empty_q;
	assign result.overflow    = res_ovf_q;
	assign result.last        = res_last_q;

endmodule

// ===== src/tks_checker.sv =====
// ---------------------------------------------------------------------------
// tks_checker
// Port-level checks of the top-k selector, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tks_checker #(
	parameter int SCORE_WIDTH = 32,
	parameter int INDEX_WIDTH = 20
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input logic                          item_operation,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic signed [SCORE_WIDTH-1:0] result_rank_score,
	input logic [INDEX_WIDTH-1:0]        result_entry_index,
	input logic [tks_pkg::RANK_W-1:0]    result_rank,
	input logic                          result_empty_res,
	input logic                          result_last
);

	// empty ranking is a single zeroed result
`TKS_ASSERT_IMP(a_empty_shape, clk, arst_n, result_valid && result_empty_res, result_last && result_rank == '0 && result_entry_index == '0 && result_rank_score == '0)

	// a finish closes the input until the ranking is out
`TKS_ASSERT_NXT(a_finish_blocks, clk, arst_n, item_valid && item_ready && item_operation == tks_pkg::OP_FINISH, !item_ready)

	// ranking streams without gaps while the sink takes it
`TKS_ASSERT_NXT(a_burst_continues, clk, arst_n, result_valid && result_ready && !result_last, result_valid)

`TKS_ASSERT_NXT(a_result_holds, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result_rank_score) && $stable(result_entry_index) && $stable(result_rank))

endmodule

bind top_k_score_select tks_checker #(
	.SCORE_WIDTH(SCORE_WIDTH),
	.INDEX_WIDTH(INDEX_WIDTH)
) u_tks_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.item_operation    (item.operation),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.result_rank_score (result.rank_score),
	.result_entry_index(result.entry_index),
	.result_rank       (result.rank),
	.result_empty_res  (result.empty_res),
	.result_last       (result.last)
);
